### src/smda_pkg.sv
// Shared types and constants for the deferred acceptance matching unit.
// No dependencies.
package smda_pkg;

  localparam int MAX_PROPOSERS = 16;
  localparam int MAX_REVIEWERS = 16;
  localparam int PW = 4;
  localparam int RW = 4;
  localparam int TAB_AW = PW + RW;
  localparam int TAB_DEPTH = MAX_PROPOSERS * MAX_REVIEWERS;

  localparam logic [1:0] CMD_PREF = 2'd0;
  localparam logic [1:0] CMD_UTIL = 2'd1;
  localparam logic [1:0] CMD_RUN  = 2'd2;

  localparam logic [0:0] REG_PCOUNT = 1'b0;
  localparam logic [0:0] REG_RCOUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  row_index;
    logic [3:0]  column_index;
    logic [3:0]  preferred_reviewer;
    logic [31:0] utility_value;
  } in_item_t;

  typedef struct packed {
    logic       side;
    logic [3:0] agent_index;
    logic [3:0] partner_index;
    logic       is_matched;
    logic       last_result;
  } out_item_t;

endpackage

### src/stable_matching_deferred_acceptance_unit.sv
// Deferred acceptance (proposer-optimal stable matching) engine, top level.
// Depends on smda_pkg and smda_ram.
//
// Table loads (commands 0 and 1) and command 3 are taken in the idle state
// and the block stays ready, so loads may follow back to back. A run item
// walks the proposals under a small sequencer with one shared signed
// comparator. After the accepting edge the queue is seeded with
// proposer_count entries; each queue entry is then popped and retired. Each
// rank scanned steps through address, preference read and check when the
// reviewer is free or out of use, with two utility reads and the compare
// added when it is held; an exhausted list goes straight to retire. The empty
// queue starts the output: proposer_count proposer entries and then
// reviewer_count reviewer entries, one per cycle while the sink is ready; a
// stalled sink holds the entry in place.
// The block accepts no item from the run request until the last entry is
// taken, and is ready again on the cycle after.
module stable_matching_deferred_acceptance_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] command, [5:2] row_index, [9:6] column_index,
  // [13:10] preferred_reviewer, [45:14] utility_value, [47:46] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] side, [4:1] agent_index, [8:5] partner_index, [9] is_matched,
  // [15:10] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);
  import smda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_POP, S_PREF, S_PREFW, S_CHK, S_UTLP, S_UTLH, S_CMP,
    S_NEXT, S_EMIT
  } state_t;

  state_t state_r;
  logic [4:0] pcount_r, rcount_r;
  logic [4:0] np_r, nr_r;
  logic [PW-1:0] holder_r [MAX_REVIEWERS];
  logic [MAX_REVIEWERS-1:0] held_r;
  logic [RW-1:0] partner_r [MAX_PROPOSERS];
  logic [MAX_PROPOSERS-1:0] matched_r;
  logic [PW-1:0] queue_r [MAX_PROPOSERS];
  logic [PW-1:0] qhead_r;
  logic [4:0] qcount_r;
  logic [PW-1:0] p_r, h_r;
  logic [RW-1:0] w_r;
  logic [4:0] k_r;
  logic [4:0] seed_r;
  logic [31:0] up_r;
  logic [5:0] emit_r;
  out_item_t obuf_r;
  logic ovalid_r;

  in_item_t in_item;
  assign in_item = in_item_t'({in_tdata[1:0], in_tdata[5:2], in_tdata[9:6],
                               in_tdata[13:10], in_tdata[45:14]});

  logic in_fire;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // table memories
  logic pref_we, util_we;
  logic [TAB_AW-1:0] pref_raddr, util_raddr;
  logic [RW-1:0] pref_rdata;
  logic [31:0] util_rdata;
  assign pref_we = in_fire && in_item.command == CMD_PREF;
  assign util_we = in_fire && in_item.command == CMD_UTIL;

  smda_ram #(.WIDTH(RW), .DEPTH(TAB_DEPTH)) u_pref (
    .clk(clk), .we(pref_we),
    .waddr({in_item.row_index, in_item.column_index}),
    .wdata(in_item.preferred_reviewer),
    .raddr(pref_raddr), .rdata(pref_rdata)
  );
  smda_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_util (
    .clk(clk), .we(util_we),
    .waddr({in_item.row_index, in_item.column_index}),
    .wdata(in_item.utility_value),
    .raddr(util_raddr), .rdata(util_rdata)
  );

  // hold the holder's address until the compare sees its utility
  assign pref_raddr = {p_r, k_r[RW-1:0]};
  assign util_raddr = (state_r == S_UTLP || state_r == S_UTLH) ? {w_r, h_r} :
                      {w_r, p_r};

  // shared signed compare
  logic greater;
  assign greater = $signed(up_r) > $signed(util_rdata);

  function automatic logic [4:0] clampc(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'd16) return 5'd16;
    return v;
  endfunction

  logic [PW-1:0] tail;
  assign tail = qhead_r + qcount_r[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcount_r <= 5'd16;
      rcount_r <= 5'd16;
      ovalid_r <= 1'b0;
      held_r <= '0;
      matched_r <= '0;
      qcount_r <= '0;
      qhead_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_PCOUNT) pcount_r <= cfg_data;
        else rcount_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (in_fire && in_item.command == CMD_RUN) begin
          np_r <= clampc(pcount_r);
          nr_r <= clampc(rcount_r);
          seed_r <= clampc(pcount_r);
          held_r <= '0;
          matched_r <= '0;
          qhead_r <= '0;
          qcount_r <= '0;
          state_r <= S_SEED;
        end
        S_SEED: begin
          // push from the highest index down
          if (seed_r == 5'd0) state_r <= S_POP;
          else begin
            queue_r[tail] <= PW'(seed_r - 5'd1);
            qcount_r <= qcount_r + 5'd1;
            seed_r <= seed_r - 5'd1;
          end
        end
        S_POP: begin
          if (qcount_r == 5'd0) begin
            emit_r <= '0;
            state_r <= S_EMIT;
          end else begin
            p_r <= ({1'b0, queue_r[qhead_r]} >= np_r) ? '0 : queue_r[qhead_r];
            k_r <= '0;
            state_r <= S_PREF;
          end
        end
        S_PREF: state_r <= (k_r >= nr_r) ? S_NEXT : S_PREFW;
        S_PREFW: begin
          w_r <= pref_rdata;
          state_r <= S_CHK;
        end
        S_CHK: begin
          if ({1'b0, w_r} >= nr_r) begin
            k_r <= k_r + 5'd1;
            state_r <= S_PREF;
          end else if (!held_r[w_r]) begin
            held_r[w_r] <= 1'b1;
            holder_r[w_r] <= p_r;
            matched_r[p_r] <= 1'b1;
            partner_r[p_r] <= w_r;
            state_r <= S_NEXT;
          end else begin
            h_r <= holder_r[w_r];
            state_r <= S_UTLP;
          end
        end
        S_UTLP: begin
          up_r <= util_rdata;
          state_r <= S_UTLH;
        end
        S_UTLH: state_r <= S_CMP;
        S_CMP: begin
          if (greater) begin
            matched_r[h_r] <= 1'b0;
            partner_r[h_r] <= '0;
            if (qcount_r < 5'(MAX_PROPOSERS)) begin
              queue_r[tail] <= h_r;
              qcount_r <= qcount_r + 5'd1;
            end
            holder_r[w_r] <= p_r;
            matched_r[p_r] <= 1'b1;
            partner_r[p_r] <= w_r;
            state_r <= S_NEXT;
          end else begin
            k_r <= k_r + 5'd1;
            state_r <= S_PREF;
          end
        end
        S_NEXT: begin
          // retire head; a push this step already counted
          qhead_r <= qhead_r + PW'(1);
          qcount_r <= qcount_r - 5'd1;
          state_r <= S_POP;
        end
        S_EMIT: begin
          if (!ovalid_r || out_tready) begin
            if (emit_r == {1'b0, np_r} + {1'b0, nr_r}) begin
              ovalid_r <= 1'b0;
              if (!ovalid_r || out_tready) state_r <= S_IDLE;
            end else begin
              ovalid_r <= 1'b1;
              if (emit_r < {1'b0, np_r}) begin
                obuf_r.side <= 1'b0;
                obuf_r.agent_index <= emit_r[3:0];
                obuf_r.partner_index <= matched_r[emit_r[3:0]] ?
                                        partner_r[emit_r[3:0]] : '0;
                obuf_r.is_matched <= matched_r[emit_r[3:0]];
                obuf_r.last_result <= 1'b0;
              end else begin
                obuf_r.side <= 1'b1;
                obuf_r.agent_index <= 4'(emit_r - {1'b0, np_r});
                obuf_r.partner_index <= held_r[4'(emit_r - {1'b0, np_r})] ?
                                        holder_r[4'(emit_r - {1'b0, np_r})] : '0;
                obuf_r.is_matched <= held_r[4'(emit_r - {1'b0, np_r})];
                obuf_r.last_result <=
                  (emit_r + 6'd1 == {1'b0, np_r} + {1'b0, nr_r});
              end
              emit_r <= emit_r + 6'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tlast = obuf_r.last_result;
  assign out_tdata = {6'd0, obuf_r.is_matched, obuf_r.partner_index,
                      obuf_r.agent_index, obuf_r.side};
endmodule

### src/smda_ram.sv
// Generic single-port write, single-port registered read RAM.
// No dependencies.
module smda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### tb/sv/tb_stable_matching_deferred_acceptance_unit.sv
// Self-checking testbench for the deferred acceptance matching unit.
// Loads preference and utility tables, runs matchings and checks every
// partner entry against a behavioural predictor. Depends on smda_pkg.
`timescale 1ns / 1ps

module tb_stable_matching_deferred_acceptance_unit;
  import smda_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  stable_matching_deferred_acceptance_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [3:0]  pref_tab [MAX_PROPOSERS][MAX_REVIEWERS];
  logic [31:0] util_tab [MAX_REVIEWERS][MAX_PROPOSERS];
  logic [4:0]  pcount_reg, rcount_reg;

  in_item_t  request_q [$];
  out_item_t partner_q [$];
  int        errors;
  int        cycles;
  bit        quiet;   // no idling on either side
  bit        hold_in; // sender waits for every pending entry
  bit        in_acc;  // request taken at the last rising edge

  task automatic report_mismatch(input string what, input out_item_t got,
                                 input out_item_t exp_item);
    $display("mismatch %s: got %h expected %h", what, got, exp_item);
    errors++;
  endtask

  function automatic int clamp_n(input logic [4:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic predict_matching();
    int np, nr, p, k, w, h, head, cnt;
    bit          held [MAX_REVIEWERS];
    int          holder [MAX_REVIEWERS];
    bit          matched [MAX_PROPOSERS];
    int          partner [MAX_PROPOSERS];
    int          fq [MAX_PROPOSERS];
    out_item_t   o;
    np = clamp_n(pcount_reg, MAX_PROPOSERS);
    nr = clamp_n(rcount_reg, MAX_REVIEWERS);
    for (int i = 0; i < MAX_REVIEWERS; i++) begin
      held[i] = 0; holder[i] = 0;
    end
    for (int i = 0; i < MAX_PROPOSERS; i++) begin
      matched[i] = 0; partner[i] = 0;
    end
    head = 0; cnt = 0;
    for (int i = np - 1; i >= 0; i--) begin
      fq[cnt] = i; cnt++;
    end
    while (cnt > 0) begin
      p = fq[head];
      for (k = 0; k < nr; k++) begin
        w = pref_tab[p][k];
        if (w >= nr) continue;
        if (!held[w]) begin
          held[w] = 1; holder[w] = p; matched[p] = 1; partner[p] = w;
          break;
        end
        h = holder[w];
        if ($signed(util_tab[w][p]) > $signed(util_tab[w][h])) begin
          matched[h] = 0; partner[h] = 0;
          if (cnt < MAX_PROPOSERS) begin
            fq[(head + cnt) % MAX_PROPOSERS] = h; cnt++;
          end
          holder[w] = p; matched[p] = 1; partner[p] = w;
          break;
        end
      end
      head = (head + 1) % MAX_PROPOSERS;
      cnt--;
    end
    for (int i = 0; i < np; i++) begin
      o.side = 1'b0; o.agent_index = i[3:0];
      o.partner_index = matched[i] ? partner[i][3:0] : 4'd0;
      o.is_matched = matched[i]; o.last_result = 1'b0;
      partner_q.insert(partner_q.size(), o);
    end
    for (int i = 0; i < nr; i++) begin
      o.side = 1'b1; o.agent_index = i[3:0];
      o.partner_index = held[i] ? holder[i][3:0] : 4'd0;
      o.is_matched = held[i]; o.last_result = (i + 1 == nr);
      partner_q.insert(partner_q.size(), o);
    end
  endtask

  task automatic apply_request(input in_item_t it);
    case (it.command)
      CMD_PREF: pref_tab[it.row_index][it.column_index] = it.preferred_reviewer;
      CMD_UTIL: util_tab[it.row_index][it.column_index] = it.utility_value;
      CMD_RUN:  predict_matching();
      default: ;
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // hold
    end else if (request_q.size() > 0 && !(hold_in && partner_q.size() > 0) &&
                 (quiet || $urandom_range(99) >= 31)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {2'b00, request_q[0].utility_value,
                    request_q[0].preferred_reviewer, request_q[0].column_index,
                    request_q[0].row_index, request_q[0].command};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= quiet || ($urandom_range(99) >= 31);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t got, exp_item;
    in_acc = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) apply_request(request_q.pop_front());
      if (out_tvalid && out_tready) begin
        got.side = out_tdata[0];
        got.agent_index = out_tdata[4:1];
        got.partner_index = out_tdata[8:5];
        got.is_matched = out_tdata[9];
        got.last_result = out_tlast;
        if (partner_q.size() == 0) begin
          report_mismatch("unexpected entry", got, got);
        end else begin
          exp_item = partner_q.pop_front();
          if (got.side != exp_item.side) report_mismatch("side", got, exp_item);
          if (got.agent_index != exp_item.agent_index)
            report_mismatch("agent_index", got, exp_item);
          if (got.partner_index != exp_item.partner_index)
            report_mismatch("partner_index", got, exp_item);
          if (got.is_matched != exp_item.is_matched)
            report_mismatch("is_matched", got, exp_item);
          if (got.last_result != exp_item.last_result)
            report_mismatch("last_result", got, exp_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] cmd, input int r,
                                         input int c, input int v,
                                         input logic [31:0] u);
    in_item_t it;
    it.command = cmd; it.row_index = r[3:0]; it.column_index = c[3:0];
    it.preferred_reviewer = v[3:0]; it.utility_value = u;
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    request_q.insert(request_q.size(), it);
  endtask

  task automatic drain();
    while (request_q.size() > 0 || partner_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_PCOUNT) pcount_reg = val; else rcount_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // fill every entry that a run of the given size reads
  task automatic load_tables(input int np_lim, input int nr_lim,
                             input bit permute);
    int perm [16];
    int j, t;
    for (int p = 0; p < np_lim; p++) begin
      for (int i = 0; i < 16; i++) perm[i] = i;
      for (int i = 15; i > 0; i--) begin
        j = $urandom_range(i); t = perm[i]; perm[i] = perm[j]; perm[j] = t;
      end
      for (int k = 0; k < nr_lim; k++)
        push_item(make_item(CMD_PREF, p, k,
                            permute ? perm[k] : $urandom_range(15), 0));
    end
    for (int w = 0; w < nr_lim; w++)
      for (int p = 0; p < np_lim; p++)
        push_item(make_item(CMD_UTIL, w, p, $urandom_range(15),
                            ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom));
  endtask

  task automatic random_phase(input int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(99);
      if (c < 45)
        push_item(make_item(CMD_PREF, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom));
      else if (c < 85)
        push_item(make_item(CMD_UTIL, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15),
                            ($urandom_range(1)) ? $urandom : $urandom_range(2)));
      else if (c < 95)
        push_item(make_item(CMD_RUN, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom));
      else
        push_item(make_item(2'd3, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom));
    end
  endtask

  initial begin
    errors = 0; cycles = 0; quiet = 0; hold_in = 0; in_acc = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_PCOUNT; cfg_data = '0;
    pcount_reg = 5'd16; rcount_reg = 5'd16;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: tiny sizes, extremes of the utility, ties, command 3
    write_reg(REG_PCOUNT, 5'd2);
    write_reg(REG_RCOUNT, 5'd2);
    push_item(make_item(CMD_PREF, 0, 0, 1, 0));
    push_item(make_item(CMD_PREF, 0, 1, 0, 0));
    push_item(make_item(CMD_PREF, 1, 0, 1, 0));
    push_item(make_item(CMD_PREF, 1, 1, 1, 0));   // repeated reviewer
    push_item(make_item(CMD_UTIL, 0, 0, 0, 32'h8000_0000));
    push_item(make_item(CMD_UTIL, 0, 1, 0, 32'h7FFF_FFFF));
    push_item(make_item(CMD_UTIL, 1, 0, 0, 32'h0001_0000));
    push_item(make_item(CMD_UTIL, 1, 1, 0, 32'h0001_0000)); // tie keeps holder
    push_item(make_item(2'd3, 15, 15, 15, 32'hFFFF_FFFF));
    push_item(make_item(CMD_RUN, 0, 0, 0, 0));
    push_item(make_item(CMD_PREF, 0, 0, 15, 0));  // reviewer out of use
    push_item(make_item(CMD_RUN, 15, 15, 15, 32'hFFFF_FFFF));
    drain();
    write_reg(REG_PCOUNT, 5'd0);                  // used as one
    write_reg(REG_RCOUNT, 5'd31);                 // used as the limit
    load_tables(1, 16, 1'b0);
    push_item(make_item(CMD_RUN, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PCOUNT, (ph == 0) ? 5'd1 : (ph == 1) ? 5'd16 :
                            5'($urandom_range(5)));
      write_reg(REG_RCOUNT, (ph == 0) ? 5'd16 : (ph == 1) ? 5'd1 :
                            5'($urandom_range(5)));
      quiet = (ph == 3);
      // sender pauses until every expected entry has come
      hold_in = (ph == 4);
      if (ph == 1) load_tables(16, 1, 1'b0);
      if (ph == 2) load_tables(5, 5, 1'b1);
      random_phase(10);
      push_item(make_item(CMD_RUN, 0, 0, 0, 0));
      drain();
    end
    quiet = 0;
    hold_in = 0;

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
